@@ src/idll_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package idll_pkg;

   // Node ids run from 1 to MAX_NODES, with 0 as the null link.
   localparam int MAX_NODES = 64;
   localparam int ID_W      = 7;
   localparam int ADDR_W    = $clog2(MAX_NODES);
   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 8;

   typedef enum logic [1:0] {
      CMD_INS_LEFT  = 2'd0,
      CMD_INS_RIGHT = 2'd1,
      CMD_DELETE    = 2'd2,
      CMD_READ_OUT  = 2'd3
   } cmd_type;

   // Where the link table read address comes from.
   typedef enum logic [1:0] {
      RD_SRC_REF  = 2'd0,
      RD_SRC_HEAD = 2'd1,
      RD_SRC_NEXT = 2'd2
   } rd_src_type;

   typedef struct packed {
      logic       rd_en;
      rd_src_type rd_src;
      logic       wr_ins1;
      logic       wr_ins2;
      logic       wr_del;
      logic       emit;
   } ctrl_cmd_type;

   typedef struct packed {
      logic op_ok;
      logic is_delete;
      logic head_empty;
      logic walk_last;
      logic out_free;
   } dp_status_type;

endpackage

`default_nettype wire

@@ src/idll_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none

module idll_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_accept,
   input  wire idll_pkg::cmd_type      req_cmd,
   input  wire idll_pkg::dp_status_type status,
   output logic                        req_ready,
   output idll_pkg::ctrl_cmd_type      ctrl
);
   import idll_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_EXEC = 4'b0010,
      ST_INS2 = 4'b0100,
      ST_WALK = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in     = state_ff;
      ctrl         = '0;
      ctrl.rd_src  = RD_SRC_REF;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               if (req_cmd == CMD_READ_OUT) begin
                  if (!status.head_empty) begin
                     ctrl.rd_en  = 1'b1;
                     ctrl.rd_src = RD_SRC_HEAD;
                     state_in    = ST_WALK;
                  end
               end else begin
                  ctrl.rd_en  = 1'b1;
                  ctrl.rd_src = RD_SRC_REF;
                  state_in    = ST_EXEC;
               end
            end
         end
         ST_EXEC: begin
            if (!status.op_ok) begin
               state_in = ST_IDLE;
            end else if (status.is_delete) begin
               ctrl.wr_del = 1'b1;
               state_in    = ST_IDLE;
            end else begin
               ctrl.wr_ins1 = 1'b1;
               state_in     = ST_INS2;
            end
         end
         ST_INS2: begin
            ctrl.wr_ins2 = 1'b1;
            state_in     = ST_IDLE;
         end
         ST_WALK: begin
            if (status.out_free) begin
               ctrl.emit = 1'b1;
               if (status.walk_last) begin
                  state_in = ST_IDLE;
               end else begin
                  ctrl.rd_en  = 1'b1;
                  ctrl.rd_src = RD_SRC_NEXT;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

@@ src/idll_dp.sv @@
`timescale 1ns / 1ps
`default_nettype none

module idll_dp (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire idll_pkg::cmd_type             req_cmd,
   input  wire logic [idll_pkg::ID_W-1:0]     req_ref,
   input  wire idll_pkg::ctrl_cmd_type        ctrl,
   output idll_pkg::dp_status_type            status,
   input  wire logic                          rsp_ready,
   output logic                               rsp_valid,
   output logic [idll_pkg::ID_W-1:0]          rsp_member,
   output logic                               rsp_last
);
   import idll_pkg::*;

   localparam logic [ID_W-1:0] NULL_ID = '0;
   localparam logic [ID_W-1:0] ONE_ID  = ID_W'(1);
   localparam logic [ID_W-1:0] MAX_ID  = ID_W'(MAX_NODES);

   // Link tables, one write and one registered read per cycle each.
   logic [ID_W-1:0] next_mem [MAX_NODES];
   logic [ID_W-1:0] prev_mem [MAX_NODES];

   logic [MAX_NODES-1:0] next_vld_ff, next_vld_in;
   logic [MAX_NODES-1:0] prev_vld_ff, prev_vld_in;
   logic [MAX_NODES-1:0] present_ff, present_in;
   logic [ID_W-1:0]      nq_raw_ff, np_raw_ff;
   logic                 nq_vld_ff, np_vld_ff;
   cmd_type              cmd_ff, cmd_in;
   logic [ID_W-1:0]      ref_ff, ref_in;
   logic [ID_W-1:0]      head_ff, head_in;
   logic [ID_W-1:0]      nid_ff, nid_in;
   logic [ID_W-1:0]      cur_ff, cur_in;
   logic                 out_vld_ff, out_vld_in;
   logic [ID_W-1:0]      out_id_ff, out_id_in;
   logic                 out_last_ff, out_last_in;

   logic [ID_W-1:0]   q_id, p_id, rd_id;
   logic [ADDR_W-1:0] rd_addr;
   logic              nx_we, pv_we;
   logic [ADDR_W-1:0] nx_wa, pv_wa;
   logic [ID_W-1:0]   nx_wd, pv_wd;
   logic              ref_present, is_right;

   function automatic logic [ADDR_W-1:0] id_addr(input logic [ID_W-1:0] id);
      return ADDR_W'(id - ONE_ID);
   endfunction

   // Entries never written read as the null link.
   assign q_id = nq_vld_ff ? nq_raw_ff : NULL_ID;
   assign p_id = np_vld_ff ? np_raw_ff : NULL_ID;

   assign ref_present = (ref_ff != NULL_ID) && (ref_ff <= MAX_ID) &&
                        present_ff[id_addr(ref_ff)];
   assign is_right    = (cmd_ff == CMD_INS_RIGHT);

   assign status.op_ok      = ref_present &&
                              ((cmd_ff == CMD_DELETE) || (nid_ff <= MAX_ID));
   assign status.is_delete  = (cmd_ff == CMD_DELETE);
   assign status.head_empty = (head_ff == NULL_ID);
   assign status.walk_last  = (q_id == NULL_ID);
   assign status.out_free   = !out_vld_ff || rsp_ready;

   always_comb begin
      unique case (ctrl.rd_src)
         RD_SRC_REF:  rd_id = req_ref;
         RD_SRC_HEAD: rd_id = head_ff;
         RD_SRC_NEXT: rd_id = q_id;
         default:     rd_id = req_ref;
      endcase
      rd_addr = id_addr(rd_id);
   end

   always_comb begin
      nx_we      = 1'b0;
      pv_we      = 1'b0;
      nx_wa      = id_addr(nid_ff);
      pv_wa      = id_addr(nid_ff);
      nx_wd      = NULL_ID;
      pv_wd      = NULL_ID;
      head_in    = head_ff;
      nid_in     = nid_ff;
      present_in = present_ff;
      cmd_in     = cmd_ff;
      ref_in     = ref_ff;
      cur_in     = cur_ff;

      if (ctrl.rd_en && (ctrl.rd_src == RD_SRC_REF)) begin
         cmd_in = req_cmd;
         ref_in = req_ref;
      end
      if (ctrl.rd_en && (ctrl.rd_src != RD_SRC_REF)) begin
         cur_in = rd_id;
      end

      if (ctrl.wr_ins1) begin
         // Links of the new node itself.
         nx_we = 1'b1;
         pv_we = 1'b1;
         nx_wd = is_right ? q_id : ref_ff;
         pv_wd = is_right ? ref_ff : p_id;
      end

      if (ctrl.wr_ins2) begin
         if (is_right) begin
            nx_we = 1'b1;
            nx_wa = id_addr(ref_ff);
            nx_wd = nid_ff;
            pv_we = (q_id != NULL_ID);
            pv_wa = id_addr(q_id);
            pv_wd = nid_ff;
         end else begin
            pv_we = 1'b1;
            pv_wa = id_addr(ref_ff);
            pv_wd = nid_ff;
            nx_we = (p_id != NULL_ID);
            nx_wa = id_addr(p_id);
            nx_wd = nid_ff;
            if (p_id == NULL_ID) begin
               head_in = nid_ff;
            end
         end
         present_in[id_addr(nid_ff)] = 1'b1;
         nid_in = nid_ff + ONE_ID;
      end

      if (ctrl.wr_del) begin
         // The victim's own links are left stale; its id is never reused.
         nx_we = (p_id != NULL_ID);
         nx_wa = id_addr(p_id);
         nx_wd = q_id;
         pv_we = (q_id != NULL_ID);
         pv_wa = id_addr(q_id);
         pv_wd = p_id;
         if (p_id == NULL_ID) begin
            head_in = q_id;
         end
         present_in[id_addr(ref_ff)] = 1'b0;
      end
   end

   always_comb begin
      next_vld_in = next_vld_ff;
      prev_vld_in = prev_vld_ff;
      if (nx_we) begin
         next_vld_in[nx_wa] = 1'b1;
      end
      if (pv_we) begin
         prev_vld_in[pv_wa] = 1'b1;
      end
   end

   always_comb begin
      out_id_in   = out_id_ff;
      out_last_in = out_last_ff;
      out_vld_in  = out_vld_ff && !rsp_ready;
      if (ctrl.emit) begin
         out_vld_in  = 1'b1;
         out_id_in   = cur_ff;
         out_last_in = (q_id == NULL_ID);
      end
   end

   always_ff @(posedge clock) begin
      if (nx_we) begin
         next_mem[nx_wa] <= nx_wd;
      end
      if (pv_we) begin
         prev_mem[pv_wa] <= pv_wd;
      end
      if (ctrl.rd_en) begin
         nq_raw_ff <= next_mem[rd_addr];
         np_raw_ff <= prev_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         next_vld_ff <= '0;
         prev_vld_ff <= '0;
         nq_vld_ff   <= 1'b0;
         np_vld_ff   <= 1'b0;
         present_ff  <= MAX_NODES'(1);
         head_ff     <= ONE_ID;
         nid_ff      <= ID_W'(2);
         out_vld_ff  <= 1'b0;
      end else begin
         next_vld_ff <= next_vld_in;
         prev_vld_ff <= prev_vld_in;
         if (ctrl.rd_en) begin
            nq_vld_ff <= next_vld_ff[rd_addr];
            np_vld_ff <= prev_vld_ff[rd_addr];
         end
         present_ff <= present_in;
         head_ff    <= head_in;
         nid_ff     <= nid_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      ref_ff      <= ref_in;
      cur_ff      <= cur_in;
      out_id_ff   <= out_id_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_valid  = out_vld_ff;
   assign rsp_member = out_id_ff;
   assign rsp_last   = out_last_ff;

endmodule

`default_nettype wire

@@ src/indexed_doubly_linked_list.sv @@
`timescale 1ns / 1ps
`default_nettype none
// An insert runs the execute and second-write states, a delete or a refused insert only the
// execute state; a read out walks the list, paced by the registered next-link table read.
// Throughput: one command at a time; a read out streams one member per cycle unless stalled.
// Reset (synchronous, active high) restores the one-node list at once: the link table valid
// bits clear in the same cycle, so there is no clearing pass.

module indexed_doubly_linked_list (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   // Fields from bit 0 up: cmd [1:0], node_ref [8:2], zero fill [15:9].
   input  wire logic [idll_pkg::REQ_DATA_W-1:0]   req_tdata,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   // Fields from bit 0 up: member_id [6:0], zero fill [7].
   output logic [idll_pkg::RSP_DATA_W-1:0]        rsp_tdata,
   output logic                                   rsp_tlast
);
   import idll_pkg::*;

   // The controller sequences each command; the datapath owns the link
   // tables, the present mask, the head and id registers and the output
   // register that parts the walk from the result channel.
   cmd_type         req_cmd;
   logic [ID_W-1:0] req_ref;
   logic            req_accept;
   ctrl_cmd_type    ctrl;
   dp_status_type   status;
   logic [ID_W-1:0] rsp_member;

   assign req_cmd    = cmd_type'(req_tdata[1:0]);
   assign req_ref    = req_tdata[ID_W+1:2];
   assign req_accept = req_tvalid && req_tready;

   idll_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_accept (req_accept),
      .req_cmd    (req_cmd),
      .status     (status),
      .req_ready  (req_tready),
      .ctrl       (ctrl)
   );

   idll_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_cmd    (req_cmd),
      .req_ref    (req_ref),
      .ctrl       (ctrl),
      .status     (status),
      .rsp_ready  (rsp_tready),
      .rsp_valid  (rsp_tvalid),
      .rsp_member (rsp_member),
      .rsp_last   (rsp_tlast)
   );

   // Each transfer on the result channel carries one member id.
   assign rsp_tdata = RSP_DATA_W'(rsp_member);

endmodule

`default_nettype wire
